>>> hw/rtl/kvst_pkg.sv
package kvst_pkg;
	localparam int SLOTS_DEF = 256;
	localparam int KEY_BYTES = 16;
	localparam int VAL_BYTES = 48;
	localparam int MAX_BUF = 49;
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_SET = 1'b1;

	// zero every byte from the first zero byte onward
	function automatic logic [383:0] cut_val(input logic [383:0] v);
		logic ended;
		logic [383:0] r;
		ended = 1'b0;
		r = v;
		for (int b = 0; b < VAL_BYTES; b++) begin
			if (ended) r[8*b +: 8] = 8'd0;
			else if (v[8*b +: 8] == 8'd0) ended = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [127:0] cut_key(input logic [127:0] k);
		logic ended;
		logic [127:0] r;
		ended = 1'b0;
		r = k;
		for (int b = 0; b < KEY_BYTES; b++) begin
			if (ended) r[8*b +: 8] = 8'd0;
			else if (k[8*b +: 8] == 8'd0) ended = 1'b1;
		end
		return r;
	endfunction
endpackage

>>> hw/rtl/kvst_ram.sv
module kvst_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> hw/rtl/key_value_slot_table.sv
// Slot table of SLOTS entries (16-byte key, 48-byte value each) held in two synchronous
// RAMs with per-slot valid flops. Every get or set scans the key RAM one slot per cycle
// through its single read port, then passes S_WAIT, S_DEC and S_RES before the result;
// a set writes key and value in S_DEC, which follows S_WAIT after the last scan state.
// The next transaction can be taken in the cycle after the result is taken. No clearing
// pass after reset. The result is held in an output register until taken.
module key_value_slot_table
	import kvst_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [63:0] key_low,
	input  logic [63:0] key_high,
	input  logic [63:0] value_word0,
	input  logic [63:0] value_word1,
	input  logic [63:0] value_word2,
	input  logic [63:0] value_word3,
	input  logic [63:0] value_word4,
	input  logic [63:0] value_word5,
	input  logic [5:0]  buffer_len,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  slot_index,
	output logic [63:0] out_word0,
	output logic [63:0] out_word1,
	output logic [63:0] out_word2,
	output logic [63:0] out_word3,
	output logic [63:0] out_word4,
	output logic [63:0] out_word5,
	output logic [8:0]  entry_count
);
	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_DEC = 3'd2,
		S_WAIT = 3'd3, S_RES = 3'd4, S_OUT = 3'd5;

	logic [2:0]       state_q;
	logic [AW:0]      scan_q;
	logic             scan_vld_s1;
	logic [AW-1:0]    scan_idx_s1;
	logic             kind_q;
	logic [127:0]     key_q;
	logic [383:0]     val_q;
	logic [5:0]       len_q;
	logic             hit_q, free_q;
	logic [AW-1:0]    hit_idx_q, free_idx_q;
	logic [SLOTS-1:0] valid_q;
	logic [CW-1:0]    total_q;
	logic [127:0]     key_rd;
	logic [383:0]     val_rd;
	logic             wr_en;
	logic [AW-1:0]    wr_idx, val_raddr;
	logic [1:0]       status_q;
	logic [7:0]       idx_q;
	logic [383:0]     res_q;
	logic             out_valid_q;
	logic [383:0]     masked;

	assign in_stall = (state_q != S_IDLE);
	assign wr_en = (state_q == S_DEC) && (kind_q == KIND_SET) && (hit_q || free_q);
	assign wr_idx = hit_q ? hit_idx_q : free_idx_q;
	assign val_raddr = hit_idx_q;

	kvst_ram #(.WIDTH(128), .DEPTH(SLOTS)) u_key_ram (
		.clk(clk), .we(wr_en), .waddr(wr_idx), .wdata(key_q),
		.raddr(scan_q[AW-1:0]), .rdata(key_rd));
	kvst_ram #(.WIDTH(384), .DEPTH(SLOTS)) u_val_ram (
		.clk(clk), .we(wr_en), .waddr(wr_idx), .wdata(val_q),
		.raddr(val_raddr), .rdata(val_rd));

	always_comb begin
		masked = '0;
		for (int b = 0; b < VAL_BYTES; b++) begin
			if (6'(b) < len_q && !(6'(b) == len_q - 6'd1)) masked[8*b +: 8] = val_rd[8*b +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scan_q <= '0;
			scan_vld_s1 <= 1'b0;
			valid_q <= '0;
			total_q <= '0;
			out_valid_q <= 1'b0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
		end else begin
			scan_vld_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q <= kind;
						key_q <= cut_key({key_high, key_low});
						val_q <= cut_val({value_word5, value_word4, value_word3,
							value_word2, value_word1, value_word0});
						if (buffer_len == 6'd0) len_q <= 6'd1;
						else if (buffer_len > 6'(MAX_BUF)) len_q <= 6'(MAX_BUF);
						else len_q <= buffer_len;
						hit_q <= 1'b0;
						free_q <= 1'b0;
						scan_q <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					scan_vld_s1 <= 1'b1;
					scan_idx_s1 <= scan_q[AW-1:0];
					if (scan_q == (AW+1)'(SLOTS - 1)) state_q <= S_WAIT;
					scan_q <= scan_q + 1'b1;
				end
				S_WAIT: state_q <= S_DEC;
				S_DEC: begin
					if (wr_en && !hit_q) begin
						valid_q[wr_idx] <= 1'b1;
						total_q <= total_q + 1'b1;
					end
					state_q <= S_RES;
				end
				S_RES: begin
					out_valid_q <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (scan_vld_s1) begin
				if (!hit_q && valid_q[scan_idx_s1] && key_rd == key_q) begin
					hit_q <= 1'b1;
					hit_idx_q <= scan_idx_s1;
				end
				if (!free_q && !valid_q[scan_idx_s1]) begin
					free_q <= 1'b1;
					free_idx_q <= scan_idx_s1;
				end
			end
		end
	end

	// hit slot is final after S_WAIT, so its value is addressed in S_DEC and lands in S_RES
	always_ff @(posedge clk) begin
		if (state_q == S_RES) begin
			res_q <= '0;
			idx_q <= '0;
			if (kind_q == KIND_GET) begin
				if (hit_q) begin
					status_q <= ST_DONE;
					idx_q <= 8'(hit_idx_q);
					res_q <= masked;
				end else status_q <= ST_NOT_FOUND;
			end else if (hit_q || free_q) begin
				status_q <= ST_DONE;
				idx_q <= 8'(wr_idx);
			end else status_q <= ST_FULL;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign slot_index = idx_q;
	assign out_word0 = res_q[63:0];
	assign out_word1 = res_q[127:64];
	assign out_word2 = res_q[191:128];
	assign out_word3 = res_q[255:192];
	assign out_word4 = res_q[319:256];
	assign out_word5 = res_q[383:320];
	assign entry_count = 9'(total_q);
endmodule

>>> hw/rtl/kvst_checker.sv
module kvst_props (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] status,
	input logic [7:0] slot_index,
	input logic [8:0] entry_count
);
	import kvst_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("result dropped while stalled");
	a_fail_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DONE |-> slot_index == 8'd0)
		else $error("failure with nonzero slot");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("input transaction withdrawn while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> entry_count >= $past(entry_count))
		else $error("count went down");
endmodule

bind key_value_slot_table kvst_props u_kvst_props (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status),
	.slot_index(slot_index), .entry_count(entry_count));
